// ===== rtl/das_pkg.sv =====
// shared constants, codes and types for the dna allowed symbol selector
// no dependencies; imported by dna_allowed_symbol_selector
package das_pkg;

  localparam int SYM_W     = 2;            // one nucleotide code
  localparam int SYM_NUM   = 32;           // symbols held by the history field
  localparam int HIST_W    = SYM_NUM * SYM_W;
  localparam int HIST_SYMBOLS_DEF = 32;
  localparam int GRP_SIZE  = 8;            // symbols per gc partial count
  localparam int GRP_NUM   = SYM_NUM / GRP_SIZE;
  localparam int GRP_CNT_W = $clog2(GRP_SIZE + 1);
  localparam int GC_W      = 6;            // gc count 0..32
  localparam int LIM_W     = 6;            // width of the limit registers
  localparam int COUNT_W   = 3;            // allowed count 1..4
  localparam int SLOT_NUM  = 4;
  localparam int DATA_W    = 64;
  localparam int ADDR_W    = 6;
  localparam int REG_IDX_W = 3;
  localparam int REG_LSB   = 3;            // 8-byte register stride

  typedef logic [SYM_W-1:0] sym_t;

  localparam sym_t SYM_A = 2'd0;
  localparam sym_t SYM_C = 2'd1;
  localparam sym_t SYM_G = 2'd2;
  localparam sym_t SYM_T = 2'd3;

  localparam logic [LIM_W-1:0] MAX_GC_RST  = 6'd33;
  localparam logic [LIM_W-1:0] MIN_GC_RST  = 6'd0;
  localparam logic [LIM_W-1:0] MAX_RUN_RST = 6'd4;
  localparam logic [LIM_W-1:0] RUN_MIN     = 6'd2;   // a single symbol is no run
  localparam logic [LIM_W-1:0] RUN_CAP     = 6'd32;  // longest run inside the history

  typedef enum logic [REG_IDX_W-1:0] {
    REG_WINDOW_ENABLE  = 3'd0,
    REG_GC_WINDOW_MASK = 3'd1,
    REG_MAX_GC         = 3'd2,
    REG_MIN_GC         = 3'd3,
    REG_MAX_RUN        = 3'd4
  } reg_idx_t;

endpackage

// ===== rtl/dna_allowed_symbol_selector.sv =====
// dna_allowed_symbol_selector: an accepted beat passes the stage 1 and stage 2 registers, and
// out_valid rises when it is loaded into the output register, where the result beat waits to be taken
// throughput one beat per clock unless the result side stalls; three register stages (gc tally / run detect,
// gc sum / run compare, limit compare / slot select) each stall only when full and blocked
// synchronous active-low reset empties the pipeline and loads the register defaults:
// window off, gc mask 0, max_gc 33, min_gc 0, max_run 4
// uses das_pkg
module dna_allowed_symbol_selector #(
  parameter int HISTORY_SYMBOLS = das_pkg::HIST_SYMBOLS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input beat
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [das_pkg::HIST_W-1:0]   in_history_code,
  // result beat
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [das_pkg::COUNT_W-1:0]  out_allowed_count,
  output logic [das_pkg::SYM_W-1:0]    out_allowed_slot_0,
  output logic [das_pkg::SYM_W-1:0]    out_allowed_slot_1,
  output logic [das_pkg::SYM_W-1:0]    out_allowed_slot_2,
  output logic [das_pkg::SYM_W-1:0]    out_allowed_slot_3,
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [das_pkg::ADDR_W-1:0]   paddr,
  input  logic [das_pkg::DATA_W-1:0]   pwdata,
  output logic [das_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import das_pkg::*;

  // ---------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------
  logic              window_enable_r;
  logic [HIST_W-1:0] gc_window_mask_r;
  logic [LIM_W-1:0]  max_gc_r;
  logic [LIM_W-1:0]  min_gc_r;
  logic [LIM_W-1:0]  max_run_r;

  reg_idx_t reg_idx;
  logic     reg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[REG_LSB +: REG_IDX_W]);
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_enable_r  <= 1'b0;
      gc_window_mask_r <= '0;
      max_gc_r         <= MAX_GC_RST;
      min_gc_r         <= MIN_GC_RST;
      max_run_r        <= MAX_RUN_RST;
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_WINDOW_ENABLE:  window_enable_r  <= pwdata[0];
        REG_GC_WINDOW_MASK: gc_window_mask_r <= pwdata[HIST_W-1:0];
        REG_MAX_GC:         max_gc_r         <= pwdata[LIM_W-1:0];
        REG_MIN_GC:         min_gc_r         <= pwdata[LIM_W-1:0];
        REG_MAX_RUN:        max_run_r        <= pwdata[LIM_W-1:0];
        default: ;  // addresses past the register list are ignored
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WINDOW_ENABLE:  prdata = DATA_W'(window_enable_r);
      REG_GC_WINDOW_MASK: prdata = DATA_W'(gc_window_mask_r);
      REG_MAX_GC:         prdata = DATA_W'(max_gc_r);
      REG_MIN_GC:         prdata = DATA_W'(min_gc_r);
      REG_MAX_RUN:        prdata = DATA_W'(max_run_r);
      default:            prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // pipeline handshake: a stage takes a beat when empty or draining
  // ---------------------------------------------------------------
  logic s1_valid_r, s2_valid_r;
  logic s1_ready, s2_ready, s3_ready;

  assign s3_ready = !out_valid || out_ready;
  assign s2_ready = !s2_valid_r || s3_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;

  // ---------------------------------------------------------------
  // stage 1: per-symbol gc bits in groups of eight, run match flags
  // ---------------------------------------------------------------
  logic [GRP_CNT_W-1:0] s1_grp_cnt_nxt [GRP_NUM];
  logic [SYM_NUM-1:0]   s1_eq_nxt;
  sym_t                 s1_last_nxt;

  logic [GRP_CNT_W-1:0] s1_grp_cnt_r [GRP_NUM];
  logic [SYM_NUM-1:0]   s1_eq_r;
  sym_t                 s1_last_r;

  always_comb begin
    sym_t               sym;
    logic [SYM_NUM-1:0] gc_bit;
    s1_last_nxt = in_history_code[SYM_W-1:0];
    for (int i = 0; i < SYM_NUM; i++) begin
      // symbols past the history read as A
      sym = (i < HISTORY_SYMBOLS) ? in_history_code[SYM_W*i +: SYM_W] : SYM_A;
      // each code bit is masked on its own, so a half mask counts odd codes or upper codes
      gc_bit[i]    = (sym[0] & gc_window_mask_r[SYM_W*i]) ^
                     (sym[1] & gc_window_mask_r[SYM_W*i+1]);
      s1_eq_nxt[i] = (sym == s1_last_nxt);
    end
    for (int g = 0; g < GRP_NUM; g++) begin
      s1_grp_cnt_nxt[g] = '0;
      for (int j = 0; j < GRP_SIZE; j++) begin
        s1_grp_cnt_nxt[g] = s1_grp_cnt_nxt[g] + GRP_CNT_W'(gc_bit[GRP_SIZE*g+j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_grp_cnt_r <= s1_grp_cnt_nxt;
      s1_eq_r      <= s1_eq_nxt;
      s1_last_r    <= s1_last_nxt;
    end
  end

  // ---------------------------------------------------------------
  // stage 2: gc total and run length against the run limit
  // ---------------------------------------------------------------
  logic [GC_W-1:0]    s2_gc_nxt;
  logic               s2_run_nxt;
  logic [LIM_W-1:0]   run_thr;
  logic [LIM_W-1:0]   run_span;
  logic [SYM_NUM-1:0] run_need;

  logic [GC_W-1:0]    s2_gc_r;
  logic               s2_run_r;
  sym_t               s2_last_r;

  always_comb begin
    s2_gc_nxt = '0;
    for (int g = 0; g < GRP_NUM; g++) begin
      s2_gc_nxt = s2_gc_nxt + GC_W'(s1_grp_cnt_r[g]);
    end
    // limits below two act as two
    run_thr  = (max_run_r < RUN_MIN) ? RUN_MIN : max_run_r;
    run_span = (run_thr > RUN_CAP) ? RUN_CAP : run_thr;
    // positions 1..span-1 must all repeat the newest symbol
    for (int i = 0; i < SYM_NUM; i++) begin
      run_need[i] = (i != 0) && (LIM_W'(i) < run_span);
    end
    // a run longer than the history only exists for A, which the zero fill extends
    s2_run_nxt = (&(s1_eq_r | ~run_need)) &&
                 ((run_thr <= RUN_CAP) || (s1_last_r == SYM_A));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      s2_gc_r   <= s2_gc_nxt;
      s2_run_r  <= s2_run_nxt;
      s2_last_r <= s1_last_r;
    end
  end

  // ---------------------------------------------------------------
  // stage 3: gc limits and slot selection into the output register
  // ---------------------------------------------------------------
  logic [COUNT_W-1:0] cnt_nxt;
  sym_t               slot_nxt [SLOT_NUM];

  logic               out_valid_r;
  logic [COUNT_W-1:0] cnt_r;
  sym_t               slot_r [SLOT_NUM];

  always_comb begin
    cnt_nxt     = 3'd4;
    slot_nxt[0] = SYM_A;
    slot_nxt[1] = SYM_C;
    slot_nxt[2] = SYM_G;
    slot_nxt[3] = SYM_T;
    if (window_enable_r) begin
      if (GC_W'(s2_gc_r) >= max_gc_r) begin
        // high gc: A and T only, the max test wins over the min test
        slot_nxt[2] = SYM_A;
        slot_nxt[3] = SYM_A;
        if (s2_run_r && s2_last_r == SYM_A) begin
          cnt_nxt     = 3'd1;
          slot_nxt[0] = SYM_T;
          slot_nxt[1] = SYM_A;
        end else if (s2_run_r && s2_last_r == SYM_T) begin
          cnt_nxt     = 3'd1;
          slot_nxt[0] = SYM_A;
          slot_nxt[1] = SYM_A;
        end else begin
          cnt_nxt     = 3'd2;
          slot_nxt[0] = SYM_A;
          slot_nxt[1] = SYM_T;
        end
      end else if (s2_gc_r <= min_gc_r) begin
        // low gc: C and G only
        slot_nxt[2] = SYM_A;
        slot_nxt[3] = SYM_A;
        if (s2_run_r && s2_last_r == SYM_C) begin
          cnt_nxt     = 3'd1;
          slot_nxt[0] = SYM_G;
          slot_nxt[1] = SYM_A;
        end else if (s2_run_r && s2_last_r == SYM_G) begin
          cnt_nxt     = 3'd1;
          slot_nxt[0] = SYM_C;
          slot_nxt[1] = SYM_A;
        end else begin
          cnt_nxt     = 3'd2;
          slot_nxt[0] = SYM_C;
          slot_nxt[1] = SYM_G;
        end
      end else if (s2_run_r) begin
        // drop the repeated symbol, keep the rest in code order
        cnt_nxt     = 3'd3;
        slot_nxt[0] = (s2_last_r == SYM_A) ? SYM_C : SYM_A;
        slot_nxt[1] = (s2_last_r == SYM_A || s2_last_r == SYM_C) ? SYM_G : SYM_C;
        slot_nxt[2] = (s2_last_r == SYM_T) ? SYM_G : SYM_T;
        slot_nxt[3] = SYM_A;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s3_ready) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid_r) begin
      cnt_r  <= cnt_nxt;
      slot_r <= slot_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_allowed_count  = cnt_r;
  assign out_allowed_slot_0 = slot_r[0];
  assign out_allowed_slot_1 = slot_r[1];
  assign out_allowed_slot_2 = slot_r[2];
  assign out_allowed_slot_3 = slot_r[3];

endmodule

// ===== bench/tb_top.sv =====
// self-checking bench for dna_allowed_symbol_selector: random and directed history beats,
// a scoreboard fed by an in-bench selection predictor, apb register writes between phases
// depends on das_pkg and the rtl of dna_allowed_symbol_selector
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import das_pkg::*;

  localparam int unsigned HIST_SYMS = 32;      // symbols inside the history field
  localparam int unsigned RAND_BEATS = 1700;   // random history beats to send

  // one selection result as the block reports it
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    sym_t               slot0;
    sym_t               slot1;
    sym_t               slot2;
    sym_t               slot3;
  } sel_result_t;

  // clock and reset
  bit clk = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // input channel
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [HIST_W-1:0] in_history_code = '0;

  // result channel
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [COUNT_W-1:0] out_allowed_count;
  sym_t               out_allowed_slot_0;
  sym_t               out_allowed_slot_1;
  sym_t               out_allowed_slot_2;
  sym_t               out_allowed_slot_3;

  // register port
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  dna_allowed_symbol_selector DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_history_code    (in_history_code),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_allowed_count  (out_allowed_count),
    .out_allowed_slot_0 (out_allowed_slot_0),
    .out_allowed_slot_1 (out_allowed_slot_1),
    .out_allowed_slot_2 (out_allowed_slot_2),
    .out_allowed_slot_3 (out_allowed_slot_3),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // bench copy of the register file, reset values of the block
  logic              cfg_window_en = 1'b0;
  logic [63:0]       cfg_gc_mask   = '0;
  logic [LIM_W-1:0]  cfg_max_gc    = MAX_GC_RST;
  logic [LIM_W-1:0]  cfg_min_gc    = MIN_GC_RST;
  logic [LIM_W-1:0]  cfg_max_run   = MAX_RUN_RST;

  // queues and counters
  logic [HIST_W-1:0] pending_history_q[$];   // histories waiting for the driver
  sel_result_t       expected_sel_q[$];      // predicted selections in beat order
  int unsigned       beats_sent  = 0;
  int unsigned       beats_taken = 0;
  int unsigned       fail_count  = 0;

  // idle control, changed per phase
  bit          in_gaps_on    = 1'b0;
  bit          out_stalls_on = 1'b0;
  int unsigned in_gap_left   = 0;
  int unsigned out_stall_left = 0;

  function automatic sel_result_t make_sel(int unsigned n, sym_t a, sym_t b, sym_t c, sym_t d);
    sel_result_t r;
    r.count = COUNT_W'(n);
    r.slot0 = a;
    r.slot1 = b;
    r.slot2 = c;
    r.slot3 = d;
    return r;
  endfunction

  // which next symbols the gc window and run limit let through
  function automatic sel_result_t allowed_symbols_for(logic [HIST_W-1:0] hist);
    sym_t        newest;
    sym_t        sym;
    sym_t        keep[3];
    logic [1:0]  masked;
    int unsigned run_len;
    int unsigned run_thr;
    int unsigned gc;
    int unsigned k;
    bit          run_hit;
    if (!cfg_window_en) begin
      return make_sel(4, SYM_A, SYM_C, SYM_G, SYM_T);
    end
    // run of the newest symbol, zeros continue past the history
    newest  = hist[1:0];
    run_len = 1;
    for (int unsigned i = 1; i < 64; i++) begin
      if (i < HIST_SYMS) begin
        sym = hist[2*i +: 2];
      end else begin
        sym = SYM_A;
      end
      if (sym != newest) break;
      run_len++;
    end
    run_thr = (cfg_max_run < 2) ? 2 : cfg_max_run;
    run_hit = (run_len >= run_thr);
    // a symbol counts when exactly one of its masked bits is set
    gc = 0;
    for (int unsigned i = 0; i < HIST_SYMS; i++) begin
      masked = hist[2*i +: 2] & cfg_gc_mask[2*i +: 2];
      gc += masked[0] ^ masked[1];
    end
    if (gc >= cfg_max_gc) begin
      // too much g/c: only a and t, upper limit wins over lower
      if (run_hit && newest == SYM_A) return make_sel(1, SYM_T, SYM_A, SYM_A, SYM_A);
      if (run_hit && newest == SYM_T) return make_sel(1, SYM_A, SYM_A, SYM_A, SYM_A);
      return make_sel(2, SYM_A, SYM_T, SYM_A, SYM_A);
    end
    if (gc <= cfg_min_gc) begin
      if (run_hit && newest == SYM_C) return make_sel(1, SYM_G, SYM_A, SYM_A, SYM_A);
      if (run_hit && newest == SYM_G) return make_sel(1, SYM_C, SYM_A, SYM_A, SYM_A);
      return make_sel(2, SYM_C, SYM_G, SYM_A, SYM_A);
    end
    if (run_hit) begin
      k = 0;
      for (int unsigned c = 0; c < 4; c++) begin
        if (sym_t'(c) != newest) begin
          keep[k] = sym_t'(c);
          k++;
        end
      end
      return make_sel(3, keep[0], keep[1], keep[2], SYM_A);
    end
    return make_sel(4, SYM_A, SYM_C, SYM_G, SYM_T);
  endfunction

  // gap lengths: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // newest len symbols set to sym, the one after forced different
  function automatic logic [HIST_W-1:0] with_run(logic [HIST_W-1:0] hist, sym_t sym,
                                                 int unsigned len);
    logic [HIST_W-1:0] h;
    h = hist;
    for (int unsigned i = 0; i < len && i < HIST_SYMS; i++) h[2*i +: 2] = sym;
    if (len < HIST_SYMS && h[2*len +: 2] == sym) h[2*len +: 2] = sym_t'(sym + 1);
    return h;
  endfunction

  // history where roughly pct percent of the symbols are c or g
  function automatic logic [HIST_W-1:0] gc_history(int unsigned pct);
    logic [HIST_W-1:0] h;
    for (int unsigned i = 0; i < HIST_SYMS; i++) begin
      if ($urandom_range(0, 99) < pct) begin
        h[2*i +: 2] = $urandom_range(0, 1) ? SYM_C : SYM_G;
      end else begin
        h[2*i +: 2] = $urandom_range(0, 1) ? SYM_A : SYM_T;
      end
    end
    return h;
  endfunction

  function automatic logic [HIST_W-1:0] rand_bits();
    return {$urandom, $urandom};
  endfunction

  // run lengths cluster around the current run limit
  function automatic int unsigned pick_run_len();
    int unsigned thr;
    thr = (cfg_max_run < 2) ? 2 : cfg_max_run;
    if ($urandom_range(0, 9) < 6) begin
      return $urandom_range(thr - 1, (thr + 1 > HIST_SYMS) ? HIST_SYMS : thr + 1);
    end
    return $urandom_range(1, HIST_SYMS);
  endfunction

  function automatic logic [HIST_W-1:0] random_history();
    int unsigned kind;
    sym_t        sym;
    logic [HIST_W-1:0] h;
    kind = $urandom_range(0, 9);
    sym  = sym_t'($urandom_range(0, 3));
    if (kind < 4) begin
      // gc density anywhere from 0 to 100 percent, often with a run on top
      h = gc_history($urandom_range(0, 100));
      if ($urandom_range(0, 1)) h = with_run(h, sym, pick_run_len());
    end else if (kind < 7) begin
      h = with_run(rand_bits(), sym, pick_run_len());
    end else if (kind < 9) begin
      h = rand_bits();
    end else begin
      h = {32{sym}};
    end
    return h;
  endfunction

  // driver: a beat stays up until taken, then an optional gap
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && beats_sent != beats_taken) begin
      // hold the beat
    end else if (in_gap_left != 0) begin
      in_valid <= 1'b0;
      in_gap_left--;
    end else if (pending_history_q.size() != 0) begin
      in_history_code <= pending_history_q.pop_front();
      in_valid <= 1'b1;
      beats_sent++;
      in_gap_left = in_gaps_on ? idle_len() : 0;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result side back pressure
  always @(negedge clk) begin
    if (out_stall_left != 0) begin
      out_ready <= 1'b0;
      out_stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (out_stalls_on && $urandom_range(0, 2) == 0) out_stall_left = idle_len();
    end
  end

  task automatic report_field(string name, int unsigned exp_v, int unsigned got_v);
    fail_count++;
    $error("%s expected %0d got %0d", name, exp_v, got_v);
  endtask

  // monitor: predict on every taken input beat, check every taken result beat
  always @(posedge clk) begin
    sel_result_t exp_sel;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_sel_q.push_back(allowed_symbols_for(in_history_code));
        beats_taken++;
      end
      if (out_valid && out_ready) begin
        if (expected_sel_q.size() == 0) begin
          fail_count++;
          $error("result beat with no selection expected");
        end else begin
          exp_sel = expected_sel_q.pop_front();
          if (out_allowed_count !== exp_sel.count)
            report_field("allowed_count", exp_sel.count, out_allowed_count);
          if (out_allowed_slot_0 !== exp_sel.slot0)
            report_field("allowed_slot_0", exp_sel.slot0, out_allowed_slot_0);
          if (out_allowed_slot_1 !== exp_sel.slot1)
            report_field("allowed_slot_1", exp_sel.slot1, out_allowed_slot_1);
          if (out_allowed_slot_2 !== exp_sel.slot2)
            report_field("allowed_slot_2", exp_sel.slot2, out_allowed_slot_2);
          if (out_allowed_slot_3 !== exp_sel.slot3)
            report_field("allowed_slot_3", exp_sel.slot3, out_allowed_slot_3);
        end
      end
    end
  end

  // apb write: setup, access, then mirror the value in the bench copy
  task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx) << REG_LSB;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_WINDOW_ENABLE:  cfg_window_en = value[0];
      REG_GC_WINDOW_MASK: cfg_gc_mask   = value;
      REG_MAX_GC:         cfg_max_gc    = value[LIM_W-1:0];
      REG_MIN_GC:         cfg_min_gc    = value[LIM_W-1:0];
      REG_MAX_RUN:        cfg_max_run   = value[LIM_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_limits(logic [63:0] mask, int unsigned max_gc, int unsigned min_gc,
                              int unsigned max_run);
    write_reg(REG_GC_WINDOW_MASK, mask);
    write_reg(REG_MAX_GC, DATA_W'(max_gc));
    write_reg(REG_MIN_GC, DATA_W'(min_gc));
    write_reg(REG_MAX_RUN, DATA_W'(max_run));
  endtask

  // drain everything, then let the three pipeline stages settle
  task automatic wait_idle();
    while (pending_history_q.size() != 0 || beats_sent != beats_taken ||
           expected_sel_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic pick_idle_modes();
    in_gaps_on    = ($urandom_range(0, 3) != 0);
    out_stalls_on = ($urandom_range(0, 3) != 0);
  endtask

  // random register setting, extremes favored
  task automatic random_settings();
    int unsigned r;
    if ($urandom_range(0, 9) < 6)
      write_reg(REG_WINDOW_ENABLE, DATA_W'($urandom_range(0, 19) != 0));
    if ($urandom_range(0, 9) < 6) begin
      r = $urandom_range(0, 5);
      case (r)
        0: write_reg(REG_GC_WINDOW_MASK, '0);
        1: write_reg(REG_GC_WINDOW_MASK, '1);
        2: write_reg(REG_GC_WINDOW_MASK, 64'h5555_5555_5555_5555);
        3: write_reg(REG_GC_WINDOW_MASK, 64'haaaa_aaaa_aaaa_aaaa);
        4: write_reg(REG_GC_WINDOW_MASK, ~64'h0 >> (2 * $urandom_range(1, 31)));
        default: write_reg(REG_GC_WINDOW_MASK, rand_bits());
      endcase
    end
    if ($urandom_range(0, 9) < 6) begin
      r = $urandom_range(0, 9);
      write_reg(REG_MAX_GC, DATA_W'((r == 0) ? 0 : (r == 1) ? 33 : $urandom_range(0, 33)));
    end
    if ($urandom_range(0, 9) < 6) begin
      r = $urandom_range(0, 9);
      write_reg(REG_MIN_GC, DATA_W'((r == 0) ? 0 : (r == 1) ? 32 : $urandom_range(0, 32)));
    end
    if ($urandom_range(0, 9) < 6) begin
      r = $urandom_range(0, 9);
      write_reg(REG_MAX_RUN, DATA_W'((r == 0) ? 0 : (r == 1) ? 1 : (r == 2) ? 32
                                                 : $urandom_range(2, 12)));
    end
  endtask

  // stimulus and end of test
  initial begin
    int unsigned rand_sent;
    int unsigned n;
    rand_sent = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // window off after reset: all four symbols whatever the history
    pick_idle_modes();
    pending_history_q.push_back('0);
    pending_history_q.push_back('1);
    pending_history_q.push_back(rand_bits());
    wait_idle();

    // window on, full mask, default limits: runs at, just below and past the limit
    write_reg(REG_WINDOW_ENABLE, 1);
    write_limits('1, 33, 0, 4);
    pending_history_q.push_back('0);                         // all a, run reaches past history
    pending_history_q.push_back(with_run(rand_bits(), SYM_C, 4));
    pending_history_q.push_back(with_run(rand_bits(), SYM_C, 3));
    pending_history_q.push_back(with_run(rand_bits(), SYM_T, 4));
    wait_idle();

    // max_gc 0 forces a/t; run limit 0 behaves as 2
    pick_idle_modes();
    write_limits('1, 0, 0, 0);
    pending_history_q.push_back(with_run(rand_bits(), SYM_A, 2));
    pending_history_q.push_back(with_run(rand_bits(), SYM_T, 2));
    pending_history_q.push_back(with_run(rand_bits(), SYM_C, 5)); // run of an excluded symbol
    pending_history_q.push_back({32{SYM_C}});
    wait_idle();

    // min_gc 32 forces c/g; run limit 1 behaves as 2
    write_limits('1, 33, 32, 1);
    pending_history_q.push_back(with_run(rand_bits(), SYM_C, 2));
    pending_history_q.push_back(with_run(rand_bits(), SYM_G, 2));
    pending_history_q.push_back(with_run(rand_bits(), SYM_A, 7));
    pending_history_q.push_back(with_run(rand_bits(), SYM_G, 1));
    wait_idle();

    // both gc limits met: upper limit wins
    pick_idle_modes();
    write_limits('1, 5, 20, 4);
    pending_history_q.push_back(gc_history(40));
    pending_history_q.push_back(gc_history(50));
    wait_idle();

    // low bit of each symbol counted, longest run limit
    write_limits(64'h5555_5555_5555_5555, 20, 10, 32);
    pending_history_q.push_back({32{SYM_C}});
    pending_history_q.push_back({32{SYM_T}});
    pending_history_q.push_back(with_run(rand_bits(), SYM_T, 31));
    wait_idle();

    // high bit of each symbol counted, narrow band
    pick_idle_modes();
    write_limits(64'haaaa_aaaa_aaaa_aaaa, 8, 3, 32);
    pending_history_q.push_back('0);
    pending_history_q.push_back({32{SYM_G}});
    pending_history_q.push_back(gc_history(30));
    wait_idle();

    // random phases, registers only touched when the block is drained
    while (rand_sent < RAND_BEATS) begin
      pick_idle_modes();
      random_settings();
      n = $urandom_range(60, 200);
      for (int unsigned j = 0; j < n; j++) pending_history_q.push_back(random_history());
      rand_sent += n;
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("dna_allowed_symbol_selector: match");
    end else begin
      $display("dna_allowed_symbol_selector: mismatch");
    end
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin
    #20_000_000;
    $display("dna_allowed_symbol_selector: mismatch");
    $finish;
  end

endmodule
